// ===== design/btpc_pkg.sv =====
package btpc_pkg;

    localparam int unsigned RawW = 20;
    localparam int unsigned PcW = 7;
    localparam logic [PcW-1:0] PressStart = 7'd24;

    typedef enum logic [1:0] {
        CFG_TEMP      = 2'd0,
        CFG_PRESS_LOW = 2'd1,
        CFG_PRESS_HI  = 2'd2,
        CFG_PRESS_P9  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_LOAD, OP_ADD, OP_SUB, OP_SHL, OP_ASR, OP_MUL, OP_DIV,
        OP_SETFT, OP_TOUT, OP_POUT, OP_ZCHK
    } op_t;

    typedef enum logic [4:0] {
        IMM_T1, IMM_T2, IMM_T3, IMM_P1, IMM_P2, IMM_P3, IMM_P4, IMM_P5, IMM_P6,
        IMM_P7, IMM_P8, IMM_P9, IMM_RAW, IMM_FT, IMM_C5, IMM_C128, IMM_C128000,
        IMM_C2P47, IMM_C1M, IMM_C3125
    } imm_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_EXEC, ST_WAIT, ST_WB
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] dst;
        logic [2:0] ra;
        logic [2:0] rb;
        imm_t       imm;
        logic [5:0] sh;
    } instr_t;

    typedef struct packed {
        logic   load_raw;
        logic   fetch;
        logic   exec;
        logic   wb;
        logic   out_load;
        instr_t instr;
    } cmd_t;

    typedef struct packed {
        logic unit_done;
        logic a_zero;
        logic out_busy;
    } stat_t;

    function automatic instr_t mk(op_t o, logic [2:0] d, logic [2:0] a, logic [2:0] b,
                                  imm_t m, logic [5:0] s);
        instr_t i;
        i.op = o;
        i.dst = d;
        i.ra = a;
        i.rb = b;
        i.imm = m;
        i.sh = s;
        return i;
    endfunction

    function automatic instr_t prog(logic [PcW-1:0] pc);
        instr_t i;
        case (pc)
            7'd0:  i = mk(OP_LOAD, 3'd0, 3'd0, 3'd0, IMM_RAW, 6'd0);
            7'd1:  i = mk(OP_ASR,  3'd1, 3'd0, 3'd0, IMM_T1, 6'd3);
            7'd2:  i = mk(OP_LOAD, 3'd2, 3'd0, 3'd0, IMM_T1, 6'd0);
            7'd3:  i = mk(OP_SHL,  3'd3, 3'd2, 3'd0, IMM_T1, 6'd1);
            7'd4:  i = mk(OP_SUB,  3'd1, 3'd1, 3'd3, IMM_T1, 6'd0);
            7'd5:  i = mk(OP_LOAD, 3'd3, 3'd0, 3'd0, IMM_T2, 6'd0);
            7'd6:  i = mk(OP_MUL,  3'd1, 3'd1, 3'd3, IMM_T1, 6'd0);
            7'd7:  i = mk(OP_ASR,  3'd1, 3'd1, 3'd0, IMM_T1, 6'd11);
            7'd8:  i = mk(OP_ASR,  3'd4, 3'd0, 3'd0, IMM_T1, 6'd4);
            7'd9:  i = mk(OP_SUB,  3'd4, 3'd4, 3'd2, IMM_T1, 6'd0);
            7'd10: i = mk(OP_MUL,  3'd4, 3'd4, 3'd4, IMM_T1, 6'd0);
            7'd11: i = mk(OP_ASR,  3'd4, 3'd4, 3'd0, IMM_T1, 6'd12);
            7'd12: i = mk(OP_LOAD, 3'd3, 3'd0, 3'd0, IMM_T3, 6'd0);
            7'd13: i = mk(OP_MUL,  3'd4, 3'd4, 3'd3, IMM_T1, 6'd0);
            7'd14: i = mk(OP_ASR,  3'd4, 3'd4, 3'd0, IMM_T1, 6'd14);
            7'd15: i = mk(OP_ADD,  3'd1, 3'd1, 3'd4, IMM_T1, 6'd0);
            7'd16: i = mk(OP_SETFT, 3'd0, 3'd1, 3'd0, IMM_T1, 6'd0);
            7'd17: i = mk(OP_LOAD, 3'd1, 3'd0, 3'd0, IMM_FT, 6'd0);
            7'd18: i = mk(OP_LOAD, 3'd3, 3'd0, 3'd0, IMM_C5, 6'd0);
            7'd19: i = mk(OP_MUL,  3'd1, 3'd1, 3'd3, IMM_T1, 6'd0);
            7'd20: i = mk(OP_LOAD, 3'd3, 3'd0, 3'd0, IMM_C128, 6'd0);
            7'd21: i = mk(OP_ADD,  3'd1, 3'd1, 3'd3, IMM_T1, 6'd0);
            7'd22: i = mk(OP_ASR,  3'd1, 3'd1, 3'd0, IMM_T1, 6'd8);
            7'd23: i = mk(OP_TOUT, 3'd0, 3'd1, 3'd0, IMM_T1, 6'd0);
            7'd24: i = mk(OP_LOAD, 3'd0, 3'd0, 3'd0, IMM_FT, 6'd0);
            7'd25: i = mk(OP_LOAD, 3'd1, 3'd0, 3'd0, IMM_C128000, 6'd0);
            7'd26: i = mk(OP_SUB,  3'd0, 3'd0, 3'd1, IMM_T1, 6'd0);
            7'd27: i = mk(OP_MUL,  3'd1, 3'd0, 3'd0, IMM_T1, 6'd0);
            7'd28: i = mk(OP_LOAD, 3'd2, 3'd0, 3'd0, IMM_P6, 6'd0);
            7'd29: i = mk(OP_MUL,  3'd2, 3'd1, 3'd2, IMM_T1, 6'd0);
            7'd30: i = mk(OP_LOAD, 3'd3, 3'd0, 3'd0, IMM_P5, 6'd0);
            7'd31: i = mk(OP_MUL,  3'd3, 3'd0, 3'd3, IMM_T1, 6'd0);
            7'd32: i = mk(OP_SHL,  3'd3, 3'd3, 3'd0, IMM_T1, 6'd17);
            7'd33: i = mk(OP_ADD,  3'd2, 3'd2, 3'd3, IMM_T1, 6'd0);
            7'd34: i = mk(OP_LOAD, 3'd3, 3'd0, 3'd0, IMM_P4, 6'd0);
            7'd35: i = mk(OP_SHL,  3'd3, 3'd3, 3'd0, IMM_T1, 6'd35);
            7'd36: i = mk(OP_ADD,  3'd2, 3'd2, 3'd3, IMM_T1, 6'd0);
            7'd37: i = mk(OP_LOAD, 3'd3, 3'd0, 3'd0, IMM_P3, 6'd0);
            7'd38: i = mk(OP_MUL,  3'd3, 3'd1, 3'd3, IMM_T1, 6'd0);
            7'd39: i = mk(OP_ASR,  3'd3, 3'd3, 3'd0, IMM_T1, 6'd8);
            7'd40: i = mk(OP_LOAD, 3'd4, 3'd0, 3'd0, IMM_P2, 6'd0);
            7'd41: i = mk(OP_MUL,  3'd4, 3'd0, 3'd4, IMM_T1, 6'd0);
            7'd42: i = mk(OP_SHL,  3'd4, 3'd4, 3'd0, IMM_T1, 6'd12);
            7'd43: i = mk(OP_ADD,  3'd3, 3'd3, 3'd4, IMM_T1, 6'd0);
            7'd44: i = mk(OP_LOAD, 3'd4, 3'd0, 3'd0, IMM_C2P47, 6'd0);
            7'd45: i = mk(OP_ADD,  3'd3, 3'd3, 3'd4, IMM_T1, 6'd0);
            7'd46: i = mk(OP_LOAD, 3'd4, 3'd0, 3'd0, IMM_P1, 6'd0);
            7'd47: i = mk(OP_MUL,  3'd3, 3'd3, 3'd4, IMM_T1, 6'd0);
            7'd48: i = mk(OP_ASR,  3'd3, 3'd3, 3'd0, IMM_T1, 6'd33);
            7'd49: i = mk(OP_ZCHK, 3'd0, 3'd3, 3'd0, IMM_T1, 6'd0);
            7'd50: i = mk(OP_LOAD, 3'd4, 3'd0, 3'd0, IMM_C1M, 6'd0);
            7'd51: i = mk(OP_LOAD, 3'd5, 3'd0, 3'd0, IMM_RAW, 6'd0);
            7'd52: i = mk(OP_SUB,  3'd4, 3'd4, 3'd5, IMM_T1, 6'd0);
            7'd53: i = mk(OP_SHL,  3'd4, 3'd4, 3'd0, IMM_T1, 6'd31);
            7'd54: i = mk(OP_SUB,  3'd4, 3'd4, 3'd2, IMM_T1, 6'd0);
            7'd55: i = mk(OP_LOAD, 3'd5, 3'd0, 3'd0, IMM_C3125, 6'd0);
            7'd56: i = mk(OP_MUL,  3'd4, 3'd4, 3'd5, IMM_T1, 6'd0);
            7'd57: i = mk(OP_DIV,  3'd4, 3'd4, 3'd3, IMM_T1, 6'd0);
            7'd58: i = mk(OP_ASR,  3'd5, 3'd4, 3'd0, IMM_T1, 6'd13);
            7'd59: i = mk(OP_LOAD, 3'd6, 3'd0, 3'd0, IMM_P9, 6'd0);
            7'd60: i = mk(OP_MUL,  3'd6, 3'd6, 3'd5, IMM_T1, 6'd0);
            7'd61: i = mk(OP_MUL,  3'd6, 3'd6, 3'd5, IMM_T1, 6'd0);
            7'd62: i = mk(OP_ASR,  3'd6, 3'd6, 3'd0, IMM_T1, 6'd25);
            7'd63: i = mk(OP_LOAD, 3'd7, 3'd0, 3'd0, IMM_P8, 6'd0);
            7'd64: i = mk(OP_MUL,  3'd7, 3'd7, 3'd4, IMM_T1, 6'd0);
            7'd65: i = mk(OP_ASR,  3'd7, 3'd7, 3'd0, IMM_T1, 6'd19);
            7'd66: i = mk(OP_ADD,  3'd4, 3'd4, 3'd6, IMM_T1, 6'd0);
            7'd67: i = mk(OP_ADD,  3'd4, 3'd4, 3'd7, IMM_T1, 6'd0);
            7'd68: i = mk(OP_ASR,  3'd4, 3'd4, 3'd0, IMM_T1, 6'd8);
            7'd69: i = mk(OP_LOAD, 3'd5, 3'd0, 3'd0, IMM_P7, 6'd0);
            7'd70: i = mk(OP_SHL,  3'd5, 3'd5, 3'd0, IMM_T1, 6'd4);
            7'd71: i = mk(OP_ADD,  3'd4, 3'd4, 3'd5, IMM_T1, 6'd0);
            7'd72: i = mk(OP_POUT, 3'd0, 3'd4, 3'd0, IMM_T1, 6'd0);
            default: i = mk(OP_POUT, 3'd0, 3'd0, 3'd0, IMM_T1, 6'd0);
        endcase
        return i;
    endfunction

endpackage

// ===== design/btpc_mul.sv =====
module btpc_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] result
);
    logic [1:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] opx, opy;

    always_comb begin
        case (cnt_reg)
            2'd0: begin
                opx = a[31:0];
                opy = b[31:0];
            end
            2'd1: begin
                opx = a[31:0];
                opy = b[63:32];
            end
            default: begin
                opx = a[63:32];
                opy = b[31:0];
            end
        endcase
        prod_next = {32'd0, opx} * {32'd0, opy};
        acc_next = acc_reg;
        if (cnt_reg == 2'd1) begin
            acc_next = prod_reg;
        end else if (cnt_reg != 2'd0) begin
            acc_next = acc_reg + {prod_reg[31:0], 32'd0};
        end
        done = busy_reg && (cnt_reg == 2'd3);
        busy_next = start || (busy_reg && !done);
        cnt_next = start ? 2'd0 : cnt_reg + 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        prod_reg <= prod_next;
        if (busy_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign result = acc_reg;
endmodule

// ===== design/btpc_div.sv =====
module btpc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] result
);
    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg;
    logic [63:0] q_reg, q_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] d_reg;
    logic [64:0] trial;
    logic        fits;

    always_comb begin
        trial = {rem_reg, q_reg[63]};
        fits = trial >= {1'b0, d_reg};
        rem_next = fits ? 64'(trial - {1'b0, d_reg}) : trial[63:0];
        q_next = {q_reg[62:0], fits};
        done = busy_reg && (cnt_reg == 6'd63);
        busy_next = start || (busy_reg && !done);
        cnt_next = start ? 6'd0 : cnt_reg + 6'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        if (start) begin
            neg_reg <= num[63] ^ den[63];
            q_reg <= num[63] ? 64'(-num) : num;
            d_reg <= den[63] ? 64'(-den) : den;
            rem_reg <= 64'd0;
        end else if (busy_reg) begin
            q_reg <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign result = neg_reg ? 64'(-q_reg) : q_reg;
endmodule

// ===== design/btpc_ctrl.sv =====
module btpc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_opcode,
    output logic                  s_tready,
    input  btpc_pkg::stat_t       stat,
    output btpc_pkg::cmd_t        cmd
);
    import btpc_pkg::*;

    state_t         state_reg, state_next;
    logic [PcW-1:0] pc_reg, pc_next;
    instr_t         instr;
    logic           finish;

    assign instr = prog(pc_reg);

    always_comb begin
        case (instr.op)
            OP_TOUT, OP_POUT: finish = 1'b1;
            OP_ZCHK:          finish = stat.a_zero;
            default:          finish = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        pc_next = pc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_FETCH;
                    pc_next = s_opcode ? PressStart : '0;
                end
            end
            ST_FETCH: state_next = ST_EXEC;
            ST_EXEC: begin
                if (finish) begin
                    if (!stat.out_busy) begin
                        state_next = ST_IDLE;
                    end
                end else if (instr.op == OP_MUL || instr.op == OP_DIV) begin
                    state_next = ST_WAIT;
                end else begin
                    state_next = ST_FETCH;
                    pc_next = pc_reg + PcW'(1);
                end
            end
            ST_WAIT: begin
                if (stat.unit_done) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                state_next = ST_FETCH;
                pc_next = pc_reg + PcW'(1);
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        cmd.load_raw = s_tready && s_tvalid;
        cmd.fetch = (state_reg == ST_FETCH);
        cmd.exec = (state_reg == ST_EXEC) && !finish;
        cmd.wb = (state_reg == ST_WB);
        cmd.out_load = (state_reg == ST_EXEC) && finish && !stat.out_busy;
        cmd.instr = instr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg <= pc_next;
        end
    end
endmodule

// ===== design/btpc_dp.sv =====
module btpc_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [63:0]           cfg_wdata,
    input  logic [btpc_pkg::RawW-1:0] s_raw,
    input  btpc_pkg::cmd_t        cmd,
    output btpc_pkg::stat_t       stat,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [63:0]           m_tdata,
    output logic [1:0]            m_tuser
);
    import btpc_pkg::*;

    logic [47:0]     temp_cfg_reg;
    logic [63:0]     plow_cfg_reg;
    logic [63:0]     phigh_cfg_reg;
    logic [15:0]     p9_cfg_reg;
    logic [31:0]     ft_reg;
    logic [RawW-1:0] raw_reg;
    logic [63:0]     rf_mem [8];
    logic [63:0]     a_reg, b_reg;
    logic [63:0]     imm_val, alu_res, wr_data;
    logic            wr_en, alu_wr;
    logic            mul_start, div_start, mul_done, div_done;
    logic [63:0]     mul_res, div_res;
    logic            valid_reg, valid_next;
    logic            kind_reg, dz_reg;
    logic [31:0]     temp_reg, pres_reg;
    logic [31:0]     pres_sat;
    instr_t          ins;

    assign ins = cmd.instr;

    function automatic logic [63:0] sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    always_comb begin
        case (ins.imm)
            IMM_T1:      imm_val = {48'd0, temp_cfg_reg[15:0]};
            IMM_T2:      imm_val = sx16(temp_cfg_reg[31:16]);
            IMM_T3:      imm_val = sx16(temp_cfg_reg[47:32]);
            IMM_P1:      imm_val = {48'd0, plow_cfg_reg[15:0]};
            IMM_P2:      imm_val = sx16(plow_cfg_reg[31:16]);
            IMM_P3:      imm_val = sx16(plow_cfg_reg[47:32]);
            IMM_P4:      imm_val = sx16(plow_cfg_reg[63:48]);
            IMM_P5:      imm_val = sx16(phigh_cfg_reg[15:0]);
            IMM_P6:      imm_val = sx16(phigh_cfg_reg[31:16]);
            IMM_P7:      imm_val = sx16(phigh_cfg_reg[47:32]);
            IMM_P8:      imm_val = sx16(phigh_cfg_reg[63:48]);
            IMM_P9:      imm_val = sx16(p9_cfg_reg);
            IMM_RAW:     imm_val = {{(64-RawW){1'b0}}, raw_reg};
            IMM_FT:      imm_val = {{32{ft_reg[31]}}, ft_reg};
            IMM_C5:      imm_val = 64'd5;
            IMM_C128:    imm_val = 64'd128;
            IMM_C128000: imm_val = 64'd128000;
            IMM_C2P47:   imm_val = 64'd1 << 47;
            IMM_C1M:     imm_val = 64'd1048576;
            IMM_C3125:   imm_val = 64'd3125;
            default:     imm_val = 64'd0;
        endcase
    end

    always_comb begin
        alu_wr = 1'b1;
        case (ins.op)
            OP_LOAD: alu_res = imm_val;
            OP_ADD:  alu_res = a_reg + b_reg;
            OP_SUB:  alu_res = a_reg - b_reg;
            OP_SHL:  alu_res = a_reg << ins.sh;
            OP_ASR:  alu_res = 64'($signed(a_reg) >>> ins.sh);
            default: begin
                alu_res = a_reg;
                alu_wr = 1'b0;
            end
        endcase
        mul_start = cmd.exec && (ins.op == OP_MUL);
        div_start = cmd.exec && (ins.op == OP_DIV);
        wr_en = (cmd.exec && alu_wr) || cmd.wb;
        wr_data = cmd.wb ? ((ins.op == OP_DIV) ? div_res : mul_res) : alu_res;
        if (a_reg[63]) begin
            pres_sat = 32'd0;
        end else if (a_reg[62:32] != 31'd0) begin
            pres_sat = 32'hFFFF_FFFF;
        end else begin
            pres_sat = a_reg[31:0];
        end
        stat.unit_done = mul_done || div_done;
        stat.a_zero = (a_reg == 64'd0);
        stat.out_busy = valid_reg && !m_tready;
        valid_next = cmd.out_load || (valid_reg && !m_tready);
    end

    btpc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (a_reg),
        .b       (b_reg),
        .done    (mul_done),
        .result  (mul_res)
    );

    btpc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (a_reg),
        .den     (b_reg),
        .done    (div_done),
        .result  (div_res)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rf_mem[ins.dst] <= wr_data;
        end
        if (cmd.fetch) begin
            a_reg <= rf_mem[ins.ra];
            b_reg <= rf_mem[ins.rb];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_cfg_reg <= '0;
            plow_cfg_reg <= '0;
            phigh_cfg_reg <= '0;
            p9_cfg_reg <= '0;
            ft_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TEMP:      temp_cfg_reg <= cfg_wdata[47:0];
                    CFG_PRESS_LOW: plow_cfg_reg <= cfg_wdata;
                    CFG_PRESS_HI:  phigh_cfg_reg <= cfg_wdata;
                    CFG_PRESS_P9:  p9_cfg_reg <= cfg_wdata[15:0];
                    default:       p9_cfg_reg <= p9_cfg_reg;
                endcase
            end
            if (cmd.exec && ins.op == OP_SETFT) begin
                ft_reg <= a_reg[31:0];
            end
            valid_reg <= valid_next;
        end
        if (cmd.load_raw) begin
            raw_reg <= s_raw;
        end
        if (cmd.out_load) begin
            kind_reg <= (ins.op != OP_TOUT);
            dz_reg <= (ins.op == OP_ZCHK);
            temp_reg <= (ins.op == OP_TOUT) ? a_reg[31:0] : 32'd0;
            pres_reg <= (ins.op == OP_POUT) ? pres_sat : 32'd0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = {pres_reg, temp_reg};
    assign m_tuser = {dz_reg, kind_reg};
endmodule

// ===== design/baro_temp_pressure_compensation.sv =====
// Every program step passes through a fetch and an execute state; a 64-bit product on the shared 32x32
// multiplier adds a wait state and a write-back, and so does the bit-serial 64-bit divide. A zero
// divisor ends a pressure word before the divide. One word is processed at a time and the next is
// accepted in the cycle after the result is registered.
// Reset (aresetn, synchronous, active low) clears the coefficients, the fine temperature,
// the control state and the result valid flag.
module baro_temp_pressure_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // raw_reading, zero padding
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // temperature_centi, pressure_q24_8
    output logic [1:0]  m_tuser    // kind, divide_by_zero
);
    import btpc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    btpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_opcode (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    btpc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_raw     (s_tdata[RawW-1:0]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_tvalid && !m_tready))
        else $error("result register overwritten while held");
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while busy");
    a_wb_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wb |-> $past(stat.unit_done))
        else $error("write-back without unit completion");
`endif
endmodule

// ===== test/baro_temp_pressure_compensation_tb.sv =====
module baro_temp_pressure_compensation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import btpc_pkg::*;

    localparam logic MEAS_TEMP = 1'b0;
    localparam logic MEAS_PRESS = 1'b1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 300;
    localparam int LONG_HOLD = 700;

    typedef struct packed {
        logic        kind;
        logic [31:0] temp_centi;
        logic [31:0] press_q24_8;
        logic        div_zero;
    } comp_result_t;

    typedef struct {
        logic         op;
        logic [19:0]  raw;
        int           coeff_set;
        bit           fixed;
        comp_result_t fixed_res;
    } stim_row_t;

    typedef struct {
        logic [47:0] tc;
        logic [63:0] pl;
        logic [63:0] ph;
        logic [15:0] p9;
    } coeff_set_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // raw_reading, zero padding
    logic        s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // temperature_centi, pressure_q24_8
    logic [1:0]  m_tuser;   // kind, divide_by_zero

    baro_temp_pressure_compensation i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    logic [47:0] mdl_temp_coeffs;
    logic [63:0] mdl_press_low;
    logic [63:0] mdl_press_high;
    logic [15:0] mdl_p9;
    logic [31:0] mdl_fine_temp;

    comp_result_t pending_results[$];
    int error_count;
    int cycle_count;
    int temp_seen;
    int press_seen;
    int zero_div_seen;
    int clamp_seen;
    int words_sent;
    bit tx_idle_on;
    bit rx_idle_on;
    bit rx_hold_req;

    coeff_set_t coeff_sets[5];
    stim_row_t directed_rows[$];

    always #10 aclk = ~aclk;

    function automatic logic [63:0] sdiv64(longint n, longint d);
        logic [63:0] mn;
        logic [63:0] md;
        logic [63:0] q;
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        q = mn / md;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic comp_result_t compensate(logic op, logic [19:0] raw);
        comp_result_t res;
        longint r, t1, t2, t3, a, b, v1, v2, tf, x, x2, p, w1, w2;
        longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
        res = '0;
        r = {44'd0, raw};
        tf = longint'($signed(mdl_fine_temp));
        if (op == MEAS_TEMP) begin
            t1 = {48'd0, mdl_temp_coeffs[15:0]};
            t2 = longint'($signed(mdl_temp_coeffs[31:16]));
            t3 = longint'($signed(mdl_temp_coeffs[47:32]));
            a = (r >>> 3) - (t1 <<< 1);
            v1 = (a * t2) >>> 11;
            b = (r >>> 4) - t1;
            v2 = (((b * b) >>> 12) * t3) >>> 14;
            v1 = v1 + v2;
            mdl_fine_temp = v1[31:0];
            tf = longint'($signed(mdl_fine_temp));
            v1 = (tf * 5 + 128) >>> 8;
            res.temp_centi = v1[31:0];
            return res;
        end
        p1 = {48'd0, mdl_press_low[15:0]};
        p2 = longint'($signed(mdl_press_low[31:16]));
        p3 = longint'($signed(mdl_press_low[47:32]));
        p4 = longint'($signed(mdl_press_low[63:48]));
        p5 = longint'($signed(mdl_press_high[15:0]));
        p6 = longint'($signed(mdl_press_high[31:16]));
        p7 = longint'($signed(mdl_press_high[47:32]));
        p8 = longint'($signed(mdl_press_high[63:48]));
        p9 = longint'($signed(mdl_p9));
        res.kind = 1'b1;
        x = tf - 128000;
        v2 = x * x * p6;
        v2 = v2 + ((x * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        x2 = ((x * x * p3) >>> 8) + ((x * p2) <<< 12);
        x2 = (((64'sd1 <<< 47) + x2) * p1) >>> 33;
        if (x2 == 0) begin
            res.div_zero = 1'b1;
            return res;
        end
        p = 1048576 - r;
        p = sdiv64(((p <<< 31) - v2) * 3125, x2);
        w1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
        w2 = (p8 * p) >>> 19;
        p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
        if (p < 0)
            res.press_q24_8 = '0;
        else if (p > 64'sh0000_0000_FFFF_FFFF)
            res.press_q24_8 = '1;
        else
            res.press_q24_8 = p[31:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
    endtask

    task automatic load_coeffs(coeff_set_t cs);
        write_reg(CFG_TEMP, {16'd0, cs.tc});
        write_reg(CFG_PRESS_LOW, cs.pl);
        write_reg(CFG_PRESS_HI, cs.ph);
        write_reg(CFG_PRESS_P9, {48'd0, cs.p9});
        cfg_we <= 1'b0;
        mdl_temp_coeffs = cs.tc;
        mdl_press_low = cs.pl;
        mdl_press_high = cs.ph;
        mdl_p9 = cs.p9;
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (5) @(negedge aclk);
    endtask

    // Called at a falling edge; returns at a falling edge after the word is taken.
    task automatic send_word(logic op, logic [19:0] raw, bit fixed, comp_result_t fixed_res);
        comp_result_t predicted;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'd0, raw};
        do @(posedge aclk); while (!s_tready);
        predicted = compensate(op, raw);
        pending_results.push_back(fixed ? fixed_res : predicted);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [19:0] pick_raw();
        case ($urandom_range(0, 9))
            0: return 20'h00000;
            1: return 20'hFFFFF;
            default: return 20'($urandom_range(0, 20'hFFFFF));
        endcase
    endfunction

    function automatic coeff_set_t random_coeffs();
        coeff_set_t cs;
        cs.tc = 48'({$urandom(), $urandom()});
        cs.pl = {$urandom(), $urandom()};
        cs.ph = {$urandom(), $urandom()};
        cs.p9 = 16'($urandom());
        return cs;
    endfunction

    task automatic random_run(int count);
        for (int k = 0; k < count; k++)
            send_word(1'($urandom_range(0, 1)), pick_raw(), 1'b0, '0);
        end_burst();
    endtask

    initial begin
        aclk = 1'b0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                rx_hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        comp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word", m_tdata, 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.kind)
                    report_mismatch("kind", m_tuser[0], want.kind);
                if (m_tdata[31:0] !== want.temp_centi)
                    report_mismatch("temperature_centi", m_tdata[31:0], want.temp_centi);
                if (m_tdata[63:32] !== want.press_q24_8)
                    report_mismatch("pressure_q24_8", m_tdata[63:32], want.press_q24_8);
                if (m_tuser[1] !== want.div_zero)
                    report_mismatch("divide_by_zero", m_tuser[1], want.div_zero);
                if (want.kind)
                    press_seen++;
                else
                    temp_seen++;
                if (want.div_zero)
                    zero_div_seen++;
                if (want.kind && !want.div_zero &&
                    (want.press_q24_8 == '0 || want.press_q24_8 == '1))
                    clamp_seen++;
            end
        end
    end

    initial begin
        comp_result_t dz_res;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TEMP;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = MEAS_TEMP;
        error_count = 0;
        cycle_count = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        rx_hold_req = 1'b0;
        mdl_temp_coeffs = '0;
        mdl_press_low = '0;
        mdl_press_high = '0;
        mdl_p9 = '0;
        mdl_fine_temp = '0;

        coeff_sets[0] = '{48'hFC18_6743_6B70, 64'h0B27_0BD0_D643_8E7D,
                          64'hC6F8_3C8C_FFF9_008C, 16'h1770};
        coeff_sets[1] = '{'1, '1, '1, '1};
        coeff_sets[2] = '{48'h8000_8000_0000, 64'h8000_8000_8000_0001,
                          64'h8000_8000_8000_8000, 16'h8000};
        coeff_sets[3] = '{48'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF,
                          64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF};
        coeff_sets[4] = '{48'h0000_0000_0000, 64'h0000_0000_0000_0001,
                          64'h0, 16'h0};

        dz_res = '{1'b1, 32'd0, 32'd0, 1'b1};
        // Reset coefficients: zero terms, and a zero divisor for every pressure word.
        directed_rows.push_back('{MEAS_PRESS, 20'h00000, -1, 1'b1, dz_res});
        directed_rows.push_back('{MEAS_TEMP, 20'h00000, -1, 1'b1, '0});
        directed_rows.push_back('{MEAS_TEMP, 20'hFFFFF, -1, 1'b1, '0});
        directed_rows.push_back('{MEAS_PRESS, 20'hFFFFF, -1, 1'b1, dz_res});
        // Typical coefficients; the first pressure word still sees the fine temperature from the reset coefficients.
        directed_rows.push_back('{MEAS_PRESS, 20'h655AC, 0, 1'b0, '0});
        directed_rows.push_back('{MEAS_TEMP, 20'h7EED0, -1, 1'b0, '0});
        directed_rows.push_back('{MEAS_PRESS, 20'h655AC, -1, 1'b0, '0});
        directed_rows.push_back('{MEAS_TEMP, 20'h00000, -1, 1'b0, '0});
        directed_rows.push_back('{MEAS_PRESS, 20'h00000, -1, 1'b0, '0});
        directed_rows.push_back('{MEAS_TEMP, 20'hFFFFF, -1, 1'b0, '0});
        directed_rows.push_back('{MEAS_PRESS, 20'hFFFFF, -1, 1'b0, '0});
        directed_rows.push_back('{MEAS_TEMP, 20'h55555, -1, 1'b0, '0});
        directed_rows.push_back('{MEAS_PRESS, 20'hAAAAA, -1, 1'b0, '0});
        directed_rows.push_back('{MEAS_TEMP, 20'h80000, 1, 1'b0, '0});
        directed_rows.push_back('{MEAS_PRESS, 20'h7FFFF, -1, 1'b0, '0});
        directed_rows.push_back('{MEAS_TEMP, 20'h12345, 2, 1'b0, '0});
        directed_rows.push_back('{MEAS_PRESS, 20'h00001, -1, 1'b0, '0});
        directed_rows.push_back('{MEAS_PRESS, 20'hFFFFE, -1, 1'b0, '0});
        directed_rows.push_back('{MEAS_TEMP, 20'hFFFFF, 3, 1'b0, '0});
        directed_rows.push_back('{MEAS_PRESS, 20'h00000, -1, 1'b0, '0});
        directed_rows.push_back('{MEAS_TEMP, 20'hABCDE, 4, 1'b0, '0});
        directed_rows.push_back('{MEAS_PRESS, 20'h54321, -1, 1'b0, '0});

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].coeff_set >= 0) begin
                end_burst();
                wait_idle();
                load_coeffs(coeff_sets[directed_rows[i].coeff_set]);
            end
            send_word(directed_rows[i].op, directed_rows[i].raw,
                      directed_rows[i].fixed, directed_rows[i].fixed_res);
        end
        end_burst();

        // Receiver holds off while the sender keeps offering words.
        wait_idle();
        load_coeffs(coeff_sets[0]);
        rx_hold_req = 1'b1;
        random_run(6);

        for (int ph = 0; ph < 9; ph++) begin
            wait_idle();
            case (ph)
                1: load_coeffs(coeff_sets[1]);
                2: load_coeffs(coeff_sets[2]);
                3: load_coeffs(coeff_sets[3]);
                4: load_coeffs(coeff_sets[0]);
                default: load_coeffs(random_coeffs());
            endcase
            if (ph == 8) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            random_run(ph == 0 || ph == 4 || ph == 8 ? 80 : 45);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d words over typical, extreme and random coefficient sets.",
                 words_sent);
        $display("Checked %0d temperature and %0d pressure results %s",
                 temp_seen, press_seen, "with their flags.");
        $display("Saw %0d zero divisors and %0d clamped pressures.",
                 zero_div_seen, clamp_seen);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results missing", error_count,
                     pending_results.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
